@@ src/asc_pkg.sv @@
// Package for the air sensor scan conditioner: payload structs, FSM state type,
// operation, phase and calibration codes, and field widths.
// Has no dependencies; air_sensor_scan_conditioner and asc_checker import it.
package asc_pkg;

  // default parameter values
  localparam int unsigned SCANS_PER_REPORT_DEF = 5;
  localparam int unsigned SAMPLE_BITS_DEF      = 10;

  // field widths
  localparam int unsigned SAMPLE_W      = 10;
  localparam int unsigned FA_W          = 16;
  localparam int unsigned SUM_W         = 13;
  localparam int unsigned INDEX_SHIFT   = 10;
  localparam int unsigned TVOC_INDEX_W  = SUM_W + INDEX_SHIFT;
  localparam int unsigned BASE_W        = 16;
  localparam int unsigned PHASE_W       = 2;
  localparam int unsigned CAL_W         = 4;

  // averaging ring
  localparam int unsigned RING_DEPTH    = 4;
  localparam int unsigned RING_AW       = 2;
  localparam int unsigned AVG_DEN_W     = 3;

  // reset values and shifts
  localparam logic [FA_W-1:0]   OFFSET_RESET   = 16'd1382;
  localparam logic [BASE_W-1:0] BASELINE_RESET = 16'd1600;
  localparam int unsigned       BASELINE_SHIFT = 3;

  // operation codes
  localparam logic OP_SCAN    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // TVOC phase codes
  localparam logic [PHASE_W-1:0] PHASE_CLEAR  = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_ACCUM  = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_REPORT = 2'd2;

  // calibration steps
  localparam logic [CAL_W-1:0] CAL_START      = 4'd0;
  localparam logic [CAL_W-1:0] CAL_CLEAR_LAST = 4'd1;
  localparam logic [CAL_W-1:0] CAL_ACCUM_LAST = 4'd9;
  localparam logic [CAL_W-1:0] CAL_DIVIDE     = 4'd10;
  localparam logic [CAL_W-1:0] CAL_REPORT     = 4'd11;

  typedef struct packed {
    logic                operation;
    logic [SAMPLE_W-1:0] formaldehyde_sample;
    logic [SAMPLE_W-1:0] tvoc_sample;
    logic [SAMPLE_W-1:0] light_sample;
    logic [SAMPLE_W-1:0] aux_sample;
  } asc_in_t;

  typedef struct packed {
    logic [FA_W-1:0]         formaldehyde_average;
    logic [PHASE_W-1:0]      tvoc_phase;
    logic [SUM_W-1:0]        tvoc_raw_sum;
    logic [TVOC_INDEX_W-1:0] tvoc_index;
    logic                    baseline_zero;
    logic [SUM_W-1:0]        light_sum;
    logic [SUM_W-1:0]        aux_sum;
  } asc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } asc_state_t;

endpackage

@@ src/asc_serdiv.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Standalone; instantiated by air_sensor_scan_conditioner.
module asc_serdiv #(
  parameter int unsigned NUM_W = 23,
  parameter int unsigned DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] count;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // shift the next numerator bit into the partial remainder
  assign trial = {rem, quot[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(NUM_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot  <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      // remainder stays below the divisor, so DEN_W bits hold it
      rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule

@@ src/air_sensor_scan_conditioner.sv @@
// Air sensor scan conditioner: scan sums, formaldehyde ring average, TVOC calibration.
// Depends on asc_pkg and asc_serdiv.
// A scan that does not close a report, and a restart, are taken without leaving ST_IDLE.
// A scan that closes a report passes through ST_SCALE, ST_SUM, ST_DIV and ST_DONE; its wait in ST_DIV
// is set by the 23-bit bit-serial TVOC divider (the 16-bit average divider runs beside it).
// No new item is taken until that result is loaded into the output register.
// Synchronous active-high reset; the ring entries are not cleared and need no pass.
module air_sensor_scan_conditioner import asc_pkg::*; #(
  parameter int unsigned SCANS_PER_REPORT = SCANS_PER_REPORT_DEF,
  parameter int unsigned SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  asc_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output asc_out_t         out_data,
  input  logic             cfg_wr_en,
  input  logic [FA_W-1:0]  cfg_wr_data
);

  localparam int unsigned CNT_W = (SCANS_PER_REPORT > 1) ? $clog2(SCANS_PER_REPORT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCANS_PER_REPORT - 1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [RING_AW-1:0] WARMUP_LAST = RING_AW'(RING_DEPTH - 1);

  asc_state_t state, state_next;

  logic [CNT_W-1:0]   scan_count;
  logic [FA_W-1:0]    fa_acc;
  logic [SUM_W-1:0]   tv_acc;
  logic [SUM_W-1:0]   li_acc;
  logic [SUM_W-1:0]   ax_acc;
  logic [FA_W-1:0]    ring [RING_DEPTH];
  logic [RING_AW-1:0] ring_pos;
  logic [RING_AW-1:0] warmup_count;
  logic [CAL_W-1:0]   cal_step;
  logic [BASE_W-1:0]  baseline;
  logic [FA_W-1:0]    offset;
  logic [PHASE_W-1:0] rep_phase;
  logic               rep_warm;

  logic               in_xfer;
  logic               report_done;
  logic               div_start;
  logic               load_out;
  logic [FA_W-1:0]    fa_scaled;
  logic [FA_W-1:0]    ring_total;
  logic [AVG_DEN_W-1:0] avg_den;
  logic               avg_busy;
  logic               tv_busy;
  logic [FA_W-1:0]    avg_quot;
  logic [TVOC_INDEX_W-1:0] tv_quot;
  asc_out_t           result;

  assign in_xfer     = in_valid && in_ready;
  assign report_done = in_xfer && (in_data.operation == OP_SCAN) && (scan_count == CNT_LAST);

  // 3.5x scale: 2s + s + s/2, minus offset, modulo 2^16
  assign fa_scaled = {fa_acc[FA_W-2:0], 1'b0} + fa_acc + {1'b0, fa_acc[FA_W-1:1]} - offset;

  assign avg_den = rep_warm ? {1'b0, ring_pos} : AVG_DEN_W'(RING_DEPTH);

  always_comb begin
    ring_total = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      // during warm-up only the entries written so far count
      if (!rep_warm || (ring_pos > RING_AW'(i))) begin
        ring_total = ring_total + ring[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (report_done) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: state_next = ST_SUM;
      ST_SUM: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!avg_busy && !tv_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  asc_serdiv #(.NUM_W(FA_W), .DEN_W(AVG_DEN_W)) u_avg_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ring_total),
    .den   (avg_den),
    .busy  (avg_busy),
    .quot  (avg_quot)
  );

  asc_serdiv #(.NUM_W(TVOC_INDEX_W), .DEN_W(BASE_W)) u_tvoc_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({tv_acc, {INDEX_SHIFT{1'b0}}}),
    .den   (baseline),
    .busy  (tv_busy),
    .quot  (tv_quot)
  );

  always_comb begin
    result.formaldehyde_average = (avg_den == '0) ? '0 : avg_quot;
    result.tvoc_phase           = rep_phase;
    result.tvoc_raw_sum         = tv_acc;
    result.light_sum            = li_acc;
    result.aux_sum              = ax_acc;
    result.tvoc_index           = '0;
    result.baseline_zero        = 1'b0;
    if (rep_phase == PHASE_REPORT) begin
      if (baseline == '0) begin
        result.tvoc_index    = '1;
        result.baseline_zero = 1'b1;
      end else begin
        result.tvoc_index = tv_quot;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_count   <= '0;
      fa_acc       <= '0;
      tv_acc       <= '0;
      li_acc       <= '0;
      ax_acc       <= '0;
      ring_pos     <= '0;
      warmup_count <= '0;
      cal_step     <= CAL_REPORT;
      baseline     <= BASELINE_RESET;
      offset       <= OFFSET_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        offset <= cfg_wr_data;
      end
      if (in_xfer) begin
        if (in_data.operation == OP_RESTART) begin
          cal_step <= CAL_START;
        end else begin
          fa_acc <= fa_acc + FA_W'(in_data.formaldehyde_sample & SAMPLE_MASK);
          tv_acc <= tv_acc + SUM_W'(in_data.tvoc_sample & SAMPLE_MASK);
          li_acc <= li_acc + SUM_W'(in_data.light_sample & SAMPLE_MASK);
          ax_acc <= ax_acc + SUM_W'(in_data.aux_sample & SAMPLE_MASK);
          scan_count <= (scan_count == CNT_LAST) ? '0 : scan_count + 1'b1;
        end
      end
      if (state == ST_SCALE) begin
        ring_pos <= ring_pos + 1'b1;
        if (warmup_count < WARMUP_LAST) begin
          warmup_count <= warmup_count + 1'b1;
        end
        priority if (cal_step <= CAL_CLEAR_LAST) begin
          baseline <= '0;
          cal_step <= cal_step + 1'b1;
        end else if (cal_step <= CAL_ACCUM_LAST) begin
          baseline <= baseline + BASE_W'(tv_acc);
          cal_step <= cal_step + 1'b1;
        end else begin
          if (cal_step == CAL_DIVIDE) begin
            baseline <= baseline >> BASELINE_SHIFT;
            cal_step <= CAL_REPORT;
          end
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
        fa_acc    <= '0;
        tv_acc    <= '0;
        li_acc    <= '0;
        ax_acc    <= '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == ST_SCALE) begin
      ring[ring_pos] <= fa_scaled;
      rep_warm       <= (warmup_count < WARMUP_LAST);
      priority if (cal_step <= CAL_CLEAR_LAST) begin
        rep_phase <= PHASE_CLEAR;
      end else if (cal_step <= CAL_ACCUM_LAST) begin
        rep_phase <= PHASE_ACCUM;
      end else begin
        rep_phase <= PHASE_REPORT;
      end
    end
    if (load_out) begin
      out_data <= result;
    end
  end

endmodule

@@ src/asc_checker.sv @@
// Port-level checks for the air sensor scan conditioner, bound to the top level.
// Depends on asc_pkg and air_sensor_scan_conditioner.
module asc_checker import asc_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input asc_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input asc_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no index outside the reporting phase
  a_index_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.tvoc_phase != PHASE_REPORT)
      |-> (out_data.tvoc_index == '0) && !out_data.baseline_zero)
    else $error("tvoc index outside reporting phase");

  // zero baseline saturates the index
  a_zero_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.baseline_zero
      |-> (out_data.tvoc_index == '1) && (out_data.tvoc_phase == PHASE_REPORT))
    else $error("zero baseline without saturated index");

  // a restart transfer makes no result
  a_restart_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.operation == OP_RESTART) |=> !$rose(out_valid))
    else $error("result after restart transfer");

endmodule

bind air_sensor_scan_conditioner asc_checker u_asc_checker (.*);
